/* rtl/sndl_pkg.sv */
// package: shared constants and types for the short-name directory lookup
`default_nettype none
package sndl_pkg;

	localparam int NAME_LEN    = 11;
	localparam int BASE_LEN    = 8;
	localparam int EXT_LEN     = NAME_LEN - BASE_LEN;
	localparam int POS_W       = 4;
	localparam int COUNT_W     = 13;
	localparam int INDEX_W     = 12;
	localparam int MAX_ENTRIES = 4096;
	localparam int OUTQ_DEPTH  = 3;

	localparam logic [COUNT_W-1:0] LIMIT_RESET = 13'd224;

	// item kinds
	localparam logic [1:0] KIND_CHAR  = 2'd0;
	localparam logic [1:0] KIND_ENTRY = 2'd1;
	localparam logic [1:0] KIND_START = 2'd2;

	// search status codes
	localparam logic [1:0] ST_SEARCHING = 2'd0;
	localparam logic [1:0] ST_FOUND     = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;

	localparam logic [7:0] CHAR_SPACE   = 8'h20;
	localparam logic [7:0] CHAR_DOT     = 8'h2e;
	localparam logic [7:0] CHAR_NUL     = 8'h00;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
	localparam logic [7:0] CASE_OFFSET  = 8'h20;
	localparam logic [7:0] ATTR_EXCLUDE = 8'h18;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  name_char;
		logic [63:0] entry_name_head;
		logic [23:0] entry_name_ext;
		logic [7:0]  entry_attr;
	} item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [INDEX_W-1:0] match_index;
	} result_t;

endpackage
`default_nettype wire

/* rtl/sndl_ifs.sv */
// interfaces: input item, result and configuration write channels
`default_nettype none
interface sndl_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  name_char;
	logic [63:0] entry_name_head;
	logic [23:0] entry_name_ext;
	logic [7:0]  entry_attr;

	modport source (output valid, kind, name_char, entry_name_head, entry_name_ext,
		entry_attr, input ready);
	modport sink (input valid, kind, name_char, entry_name_head, entry_name_ext,
		entry_attr, output ready);
endinterface

interface sndl_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [11:0] match_index;

	modport source (output valid, status, match_index, input ready);
	modport sink (input valid, status, match_index, output ready);
endinterface

interface sndl_cfg_if;
	logic        valid;
	logic        ready;
	logic [12:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

/* rtl/sndl_core.sv */
// lookup core: target name build, entry compare and search state
`default_nettype none
module sndl_core #(
	parameter int MAX_ENTRIES = sndl_pkg::MAX_ENTRIES
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [sndl_pkg::COUNT_W-1:0]   cfg_data,
	input  wire logic                           item_valid,
	input  wire sndl_pkg::item_t                item,
	output sndl_pkg::result_t                   result
);

	localparam int MAX_W = $clog2(MAX_ENTRIES + 1);
	localparam int CMP_W = (MAX_W > sndl_pkg::COUNT_W) ? MAX_W : sndl_pkg::COUNT_W;

	logic [7:0]                   target_q [sndl_pkg::NAME_LEN];
	logic [7:0]                   target_d [sndl_pkg::NAME_LEN];
	logic [sndl_pkg::POS_W-1:0]   pos_q, pos_d;
	logic                         overflow_q, overflow_d;
	logic [sndl_pkg::COUNT_W-1:0] count_q, count_d;
	logic [sndl_pkg::COUNT_W-1:0] limit_q;
	logic [1:0]                   outcome_q, outcome_d;
	logic [sndl_pkg::INDEX_W-1:0] found_q, found_d;

	logic [7:0]       char_up;
	logic [7:0]       entry_bytes [sndl_pkg::NAME_LEN];
	logic             same;
	logic             limit_hit;
	logic [CMP_W-1:0] count_ext;

	always_comb begin
		for (int i = 0; i < sndl_pkg::BASE_LEN; i++) begin
			entry_bytes[i] = item.entry_name_head[8*i +: 8];
		end
		for (int i = 0; i < sndl_pkg::EXT_LEN; i++) begin
			entry_bytes[sndl_pkg::BASE_LEN + i] = item.entry_name_ext[8*i +: 8];
		end
	end

	always_comb begin
		same = 1'b1;
		for (int i = 0; i < sndl_pkg::NAME_LEN; i++) begin
			if (entry_bytes[i] != target_q[i]) begin
				same = 1'b0;
			end
		end
	end

	assign count_ext = CMP_W'(count_q);
	assign limit_hit = (count_ext >= CMP_W'(limit_q)) || (count_ext >= CMP_W'(MAX_ENTRIES));

	assign char_up = ((item.name_char >= sndl_pkg::CHAR_LOWER_A) &&
		(item.name_char <= sndl_pkg::CHAR_LOWER_Z)) ?
		(item.name_char - sndl_pkg::CASE_OFFSET) : item.name_char;

	always_comb begin
		target_d   = target_q;
		pos_d      = pos_q;
		overflow_d = overflow_q;
		count_d    = count_q;
		outcome_d  = outcome_q;
		found_d    = found_q;
		if (item_valid) begin
			case (item.kind)
				sndl_pkg::KIND_START: begin
					for (int i = 0; i < sndl_pkg::NAME_LEN; i++) begin
						target_d[i] = sndl_pkg::CHAR_SPACE;
					end
					pos_d      = '0;
					overflow_d = 1'b0;
					count_d    = '0;
					outcome_d  = sndl_pkg::ST_SEARCHING;
					found_d    = '0;
				end
				sndl_pkg::KIND_CHAR: begin
					if (outcome_q == sndl_pkg::ST_SEARCHING) begin
						if (pos_q >= sndl_pkg::POS_W'(sndl_pkg::NAME_LEN)) begin
							overflow_d = 1'b1;
						end else if ((item.name_char == sndl_pkg::CHAR_DOT) &&
							(pos_q < sndl_pkg::POS_W'(sndl_pkg::BASE_LEN))) begin
							pos_d = sndl_pkg::POS_W'(sndl_pkg::BASE_LEN);
						end else begin
							for (int i = 0; i < sndl_pkg::NAME_LEN; i++) begin
								if (pos_q == sndl_pkg::POS_W'(i)) begin
									target_d[i] = char_up;
								end
							end
							pos_d = pos_q + 1'b1;
						end
					end
				end
				sndl_pkg::KIND_ENTRY: begin
					if (outcome_q == sndl_pkg::ST_SEARCHING) begin
						// limit is checked ahead of end of directory
						if (overflow_q || limit_hit || (entry_bytes[0] == sndl_pkg::CHAR_NUL)) begin
							outcome_d = sndl_pkg::ST_NOT_FOUND;
						end else if (((item.entry_attr & sndl_pkg::ATTR_EXCLUDE) == 8'h00) && same) begin
							outcome_d = sndl_pkg::ST_FOUND;
							found_d   = count_q[sndl_pkg::INDEX_W-1:0];
						end else begin
							count_d = count_q + 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign result.status      = outcome_d;
	assign result.match_index = (outcome_d == sndl_pkg::ST_FOUND) ? found_d : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < sndl_pkg::NAME_LEN; i++) begin
				target_q[i] <= sndl_pkg::CHAR_SPACE;
			end
			pos_q      <= '0;
			overflow_q <= 1'b0;
			count_q    <= '0;
			outcome_q  <= sndl_pkg::ST_SEARCHING;
			found_q    <= '0;
			limit_q    <= sndl_pkg::LIMIT_RESET;
		end else begin
			target_q   <= target_d;
			pos_q      <= pos_d;
			overflow_q <= overflow_d;
			count_q    <= count_d;
			outcome_q  <= outcome_d;
			found_q    <= found_d;
			if (cfg_we) begin
				limit_q <= cfg_data;
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/sndl_outq.sv */
// result queue: small fifo that parts the core from the output channel
`default_nettype none
module sndl_outq (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire sndl_pkg::result_t push_data,
	output logic [1:0]             fill,
	sndl_out_if.source             out
);

	localparam int DEPTH = sndl_pkg::OUTQ_DEPTH;

	sndl_pkg::result_t mem_q [DEPTH];
	logic [1:0]        wr_ptr_q, rd_ptr_q, count_q;
	logic              pop;

	assign pop             = out.valid && out.ready;
	assign out.valid       = (count_q != 2'd0);
	assign out.status      = mem_q[rd_ptr_q].status;
	assign out.match_index = mem_q[rd_ptr_q].match_index;
	assign fill            = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == 2'(DEPTH - 1)) ? 2'd0 : wr_ptr_q + 2'd1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == 2'(DEPTH - 1)) ? 2'd0 : rd_ptr_q + 2'd1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

/* rtl/short_name_directory_lookup.sv */
// top level: input stage register, lookup core and result queue
// each result beat is registered in the input stage and then in the result queue before it is offered
// throughput: one item per cycle while the output side keeps taking beats
// the three-entry result queue lets input beats flow while results wait
// reset (arst_n low, asynchronous): target name all spaces, search state
// cleared, entry limit 224, pipeline and queue empty
`default_nettype none
module short_name_directory_lookup #(
	parameter int MAX_ENTRIES = sndl_pkg::MAX_ENTRIES
) (
	input wire logic clk,
	input wire logic arst_n,
	sndl_in_if.sink  in,
	sndl_out_if.source out,
	sndl_cfg_if.sink cfg
);

	logic              valid_s1;
	sndl_pkg::item_t   item_s1;
	sndl_pkg::result_t result;
	logic [1:0]        fill;
	logic [2:0]        committed;

	// queue fill plus the beat held in the input stage must leave a free slot
	assign committed = {1'b0, fill} + {2'b00, valid_s1};
	assign in.ready  = (committed < 3'(sndl_pkg::OUTQ_DEPTH));
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in.valid && in.ready;
		end
	end

	always_ff @(posedge clk) begin
		if (in.valid && in.ready) begin
			item_s1.kind            <= in.kind;
			item_s1.name_char       <= in.name_char;
			item_s1.entry_name_head <= in.entry_name_head;
			item_s1.entry_name_ext  <= in.entry_name_ext;
			item_s1.entry_attr      <= in.entry_attr;
		end
	end

	sndl_core #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg.valid && cfg.ready),
		.cfg_data   (cfg.data),
		.item_valid (valid_s1),
		.item       (item_s1),
		.result     (result)
	);

	sndl_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (valid_s1),
		.push_data (result),
		.fill      (fill),
		.out       (out)
	);

endmodule
`default_nettype wire

/* tb/sv/sndl_tb_pkg.sv */
// scoreboard for the directory lookup: expected search status per input beat
`timescale 1ns / 1ps
package sndl_tb_pkg;
	import sndl_pkg::*;

	// the fourth kind code has no meaning and only reports the status
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	class lookup_scoreboard;
		logic [7:0]         target [NAME_LEN];
		logic [POS_W-1:0]   write_pos;
		bit                 name_overflow;
		logic [COUNT_W-1:0] entry_count;
		logic [COUNT_W-1:0] entry_limit;
		logic [1:0]         outcome;
		logic [INDEX_W-1:0] found_index;
		result_t            expected_status[$];
		int unsigned        errors;

		function new();
			entry_limit = LIMIT_RESET;
			errors = 0;
			clear_search();
		endfunction

		function void clear_search();
			for (int i = 0; i < NAME_LEN; i++)
				target[i] = CHAR_SPACE;
			write_pos = '0;
			name_overflow = 1'b0;
			entry_count = '0;
			outcome = ST_SEARCHING;
			found_index = '0;
		endfunction

		function void set_limit(input logic [COUNT_W-1:0] value);
			entry_limit = value;
		endfunction

		function int pending();
			return expected_status.size();
		endfunction

		function logic [8*NAME_LEN-1:0] target_bits();
			logic [8*NAME_LEN-1:0] v;
			for (int i = 0; i < NAME_LEN; i++)
				v[8*i +: 8] = target[i];
			return v;
		endfunction

		// advance the search by one accepted beat and queue the status it reports
		function void note_item(input item_t it);
			logic [7:0] c;
			logic [7:0] ebytes [NAME_LEN];
			bit         same;
			result_t    r;
			case (it.kind)
				KIND_START: begin
					clear_search();
				end
				KIND_CHAR: begin
					if (outcome == ST_SEARCHING) begin
						c = it.name_char;
						if (write_pos >= NAME_LEN) begin
							name_overflow = 1'b1;
						end else if (c == CHAR_DOT && write_pos < BASE_LEN) begin
							write_pos = BASE_LEN;
						end else begin
							if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z)
								c = c - CASE_OFFSET;
							target[write_pos] = c;
							write_pos++;
						end
					end
				end
				KIND_ENTRY: begin
					if (outcome == ST_SEARCHING) begin
						for (int i = 0; i < BASE_LEN; i++)
							ebytes[i] = it.entry_name_head[8*i +: 8];
						for (int i = 0; i < EXT_LEN; i++)
							ebytes[BASE_LEN+i] = it.entry_name_ext[8*i +: 8];
						if (name_overflow || entry_count >= entry_limit ||
								entry_count >= MAX_ENTRIES || ebytes[0] == CHAR_NUL) begin
							outcome = ST_NOT_FOUND;
						end else begin
							same = (it.entry_attr & ATTR_EXCLUDE) == 8'h00;
							for (int i = 0; i < NAME_LEN; i++)
								if (ebytes[i] != target[i])
									same = 1'b0;
							if (same) begin
								outcome = ST_FOUND;
								found_index = entry_count[INDEX_W-1:0];
							end else begin
								entry_count++;
							end
						end
					end
				end
				default: ;
			endcase
			r.status = outcome;
			r.match_index = (outcome == ST_FOUND) ? found_index : '0;
			expected_status.push_back(r);
		endfunction

		function void check_result(input logic [1:0] status,
				input logic [INDEX_W-1:0] match_index);
			result_t want;
			if (expected_status.size() == 0) begin
				$error("result beat with nothing expected: status %0d match_index %0d",
					status, match_index);
				errors++;
				return;
			end
			want = expected_status.pop_front();
			if (status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, status);
				errors++;
			end
			if (match_index !== want.match_index) begin
				$error("match_index: expected %0d, got %0d", want.match_index, match_index);
				errors++;
			end
		endfunction
	endclass

endpackage

/* tb/sv/tb_top.sv */
// top of the directory lookup testbench: clock, reset, stimulus and result checking
`timescale 1ns / 1ps
module tb_top;
	import sndl_pkg::*;
	import sndl_tb_pkg::*;

	localparam int LONG_HOLD    = 80;
	localparam int DRAIN_CYCLES = 6;

	logic clk;
	logic arst_n;
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	int unsigned live_items;
	bit long_hold_req;
	lookup_scoreboard sb;

	sndl_in_if  in_if ();
	sndl_out_if out_if ();
	sndl_cfg_if cfg_if ();

	short_name_directory_lookup i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in(in_if),
		.out(out_if),
		.cfg(cfg_if)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#2_000_000;
		$display("tb_top NOT OK");
		$finish;
	end

	// beats are noted before results are checked, so the order within an edge never matters
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_if.valid && cfg_if.ready)
				sb.set_limit(cfg_if.data);
			if (in_if.valid && in_if.ready)
				sb.note_item('{in_if.kind, in_if.name_char, in_if.entry_name_head,
					in_if.entry_name_ext, in_if.entry_attr});
			if (out_if.valid && out_if.ready)
				sb.check_result(out_if.status, out_if.match_index);
		end
	end

	initial begin : receiver
		out_if.ready = 1'b0;
		@(negedge clk);
		forever begin
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				repeat (LONG_HOLD) begin
					out_if.ready <= 1'b0;
					@(negedge clk);
				end
			end else begin
				out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
				@(negedge clk);
			end
		end
	end

	function automatic item_t make_item(input logic [1:0] kind);
		item_t it;
		it.kind = kind;
		it.name_char = 8'($urandom());
		it.entry_name_head = {$urandom(), $urandom()};
		it.entry_name_ext = 24'($urandom());
		it.entry_attr = 8'($urandom());
		return it;
	endfunction

	function automatic item_t char_item(input logic [7:0] c);
		item_t it;
		it = make_item(KIND_CHAR);
		it.name_char = c;
		return it;
	endfunction

	function automatic item_t entry_item(input logic [8*NAME_LEN-1:0] nm,
			input logic [7:0] attr);
		item_t it;
		it = make_item(KIND_ENTRY);
		it.entry_name_head = nm[63:0];
		it.entry_name_ext = nm[8*NAME_LEN-1:64];
		it.entry_attr = attr;
		return it;
	endfunction

	function automatic logic [8*NAME_LEN-1:0] random_name();
		return (8*NAME_LEN)'({$urandom(), $urandom(), $urandom()});
	endfunction

	// mostly ordinary file name characters, now and then any byte at all
	function automatic logic [7:0] name_char_pick();
		case ($urandom_range(0, 15))
			0:             return 8'($urandom());
			1, 2, 3, 4, 5: return 8'($urandom_range(8'h61, 8'h7a));
			12, 13, 14:    return 8'($urandom_range(8'h30, 8'h39));
			15:            return 8'($urandom_range(8'h21, 8'h2f));
			default:       return 8'($urandom_range(8'h41, 8'h5a));
		endcase
	endfunction

	task automatic send_item(input item_t it);
		int unsigned gap;
		gap = 0;
		while ($urandom_range(0, 99) < send_idle_pct && gap < 40)
			gap++;
		if (gap != 0) begin
			in_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		live_items++;
		in_if.valid <= 1'b1;
		in_if.kind <= it.kind;
		in_if.name_char <= it.name_char;
		in_if.entry_name_head <= it.entry_name_head;
		in_if.entry_name_ext <= it.entry_name_ext;
		in_if.entry_attr <= it.entry_attr;
		do @(posedge clk); while (!in_if.ready);
		@(negedge clk);
	endtask

	task automatic drain_results();
		in_if.valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_limit(input logic [COUNT_W-1:0] value);
		drain_results();
		cfg_if.valid <= 1'b1;
		cfg_if.data <= value;
		do @(posedge clk); while (!cfg_if.ready);
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	// one search: start beat, name characters and a run of entries, now and then with stray beats
	task automatic run_search();
		int base_len;
		int ext_len;
		int n_entries;
		int hit_at;
		logic [8*NAME_LEN-1:0] nm;
		logic [7:0] attr;
		send_item(make_item(KIND_START));
		if ($urandom_range(0, 29) == 0)
			send_item(make_item(KIND_UNUSED));
		if ($urandom_range(0, 11) == 0) begin
			// runs past the last slot of the name
			repeat ($urandom_range(12, 14))
				send_item(char_item(8'($urandom_range(8'h41, 8'h5a))));
		end else begin
			base_len = $urandom_range(0, 8);
			ext_len = $urandom_range(0, 3);
			repeat (base_len) send_item(char_item(name_char_pick()));
			if (ext_len != 0 || $urandom_range(0, 3) == 0)
				send_item(char_item(CHAR_DOT));
			repeat (ext_len) send_item(char_item(name_char_pick()));
		end
		n_entries = $urandom_range(1, 16);
		hit_at = $urandom_range(0, n_entries + 2);
		for (int i = 0; i < n_entries; i++) begin
			nm = sb.target_bits();
			attr = 8'($urandom());
			if (i == hit_at) begin
				attr = attr & ~ATTR_EXCLUDE;
			end else begin
				case ($urandom_range(0, 4))
					0: nm[8*$urandom_range(0, NAME_LEN-1) +: 8] ^= 8'(1 << $urandom_range(0, 7));
					1: attr = attr | ($urandom_range(0, 1) ? 8'h08 : 8'h10);
					2: begin
						nm = random_name();
						if (nm[7:0] == CHAR_NUL)
							nm[7:0] = 8'h41;
					end
					3: nm[7:0] = 8'he5;
					default: nm = random_name();
				endcase
			end
			send_item(entry_item(nm, attr));
		end
		if ($urandom_range(0, 3) == 0) begin
			nm = random_name();
			nm[7:0] = CHAR_NUL;
			send_item(entry_item(nm, 8'($urandom())));
		end
		repeat ($urandom_range(0, 2))
			send_item(make_item($urandom_range(0, 1) ? KIND_CHAR : KIND_ENTRY));
	endtask

	task automatic run_searches(input int unsigned budget);
		int unsigned first;
		first = live_items;
		while (live_items - first < budget)
			run_search();
	endtask

	initial begin : stimulus
		sb = new();
		send_idle_pct = 20;
		recv_idle_pct = 50;
		live_items = 0;
		long_hold_req = 1'b0;
		in_if.valid = 1'b0;
		in_if.kind = KIND_CHAR;
		in_if.name_char = '0;
		in_if.entry_name_head = '0;
		in_if.entry_name_ext = '0;
		in_if.entry_attr = '0;
		cfg_if.valid = 1'b0;
		cfg_if.data = '0;
		arst_n = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// the target starts as all spaces, so a blank entry matches straight away
		send_item(entry_item({NAME_LEN{CHAR_SPACE}}, 8'h00));
		send_item(char_item(8'h71));
		send_item(make_item(KIND_UNUSED));
		send_item(make_item(KIND_START));
		send_item(char_item(CHAR_LOWER_A));
		send_item(char_item(CHAR_LOWER_Z));
		send_item(char_item(CHAR_NUL));
		send_item(char_item(CHAR_DOT));
		send_item(char_item(8'hff));
		send_item(entry_item(sb.target_bits(), 8'h10));
		send_item(entry_item(sb.target_bits(), 8'h08));
		send_item(entry_item(sb.target_bits(), 8'he7));
		// eight base characters, so the dot is stored, then one character too many
		send_item(make_item(KIND_START));
		for (int i = 0; i < BASE_LEN; i++)
			send_item(char_item(8'(8'h41 + i)));
		send_item(char_item(CHAR_DOT));
		send_item(char_item(8'h58));
		send_item(char_item(8'h59));
		send_item(char_item(8'h5a));
		send_item(entry_item(sb.target_bits(), 8'h00));
		send_item(make_item(KIND_START));
		send_item(entry_item(random_name() & {{(NAME_LEN-1){8'hff}}, CHAR_NUL}, 8'h00));

		write_limit(13'd0);
		run_searches(60);
		write_limit(13'd4096);
		long_hold_req = 1'b1;
		run_searches(400);

		send_idle_pct = 50;
		recv_idle_pct = 20;
		write_limit(13'd3);
		run_searches(250);
		write_limit(LIMIT_RESET);
		run_searches(200);
		drain_results();
		run_searches(200);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_limit(13'($urandom_range(1, 24)));
		run_searches(400);
		write_limit(13'd4095);
		run_searches(400);

		drain_results();
		if (sb.errors == 0 && sb.pending() == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
